// ===== rtl/nonpreemptive_priority_scheduler_defines.svh =====
// assertion macros for the priority scheduler rtl
// expects signals named clk and rst in the module that uses them
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// condition that holds at every edge out of reset
`define NPS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define NPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nps_pkg.sv =====
// shared types and constants of the priority scheduler
// no dependencies
package nps_pkg;

  localparam int SLOT_W    = 4;
  localparam int FTIME_W   = 16;
  localparam int BURST_W   = 16;
  localparam int FPRIO_W   = 8;
  localparam int CFG_W     = 5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SELECT,
    ST_FETCH,
    ST_EXEC,
    ST_REPORT
  } ctl_state_t;

  typedef enum logic [1:0] {
    PS_NEW     = 2'd0,
    PS_READY   = 2'd1,
    PS_RUNNING = 2'd2,
    PS_DONE    = 2'd3
  } proc_state_t;

  typedef struct packed {
    logic load;
    logic tick_idle;
    logic tick_begin;
    logic scan;
    logic select;
    logic exec;
    logic report;
  } nps_cmd_t;

  typedef struct packed {
    logic all_term;
    logic scan_last;
  } nps_stat_t;

endpackage

// ===== rtl/nonpreemptive_priority_scheduler.sv =====
// Non-preemptive priority scheduler. Pulse start with operation = 0 to load one process slot,
// or operation = 1 to run one time tick. A tick scans n slots, n being active_count clamped
// to MAX_PROCESSES: the scan reads one slot per cycle from the arrival and priority memories,
// then selection, the fetch of the owner's remaining work and the update follow. A tick with
// every active process finished gives its beat in the next cycle. Each result beat shows on
// the result ports for one cycle with result_strobe high and cannot be held off; busy is low
// again in that cycle.
// active_count may only be written while busy is low.
// top level; depends on nps_pkg, nps_ctrl and nps_dp
module nonpreemptive_priority_scheduler import nps_pkg::*; #(
  parameter int MAX_PROCESSES = 16,
  parameter int TIME_BITS     = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               active_count_we,
  input  logic [CFG_W-1:0]   active_count,
  input  logic               operation,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [FTIME_W-1:0] arrival_time,
  input  logic [BURST_W-1:0] burst_time,
  input  logic [FPRIO_W-1:0] priority_level,
  output logic               result_strobe,
  output logic [FTIME_W-1:0] tick_time,
  output logic               cpu_busy,
  output logic [SLOT_W-1:0]  running_slot,
  output logic [BURST_W-1:0] remaining_left,
  output logic [FTIME_W-1:0] first_start_time,
  output logic               just_finished,
  output logic [FTIME_W-1:0] finish_time,
  output logic               all_done
);

  nps_cmd_t  cmd;
  nps_stat_t stat;

  nps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  nps_dp #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .TIME_BITS     (TIME_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .active_count_we  (active_count_we),
    .active_count     (active_count),
    .slot             (slot),
    .arrival_time     (arrival_time),
    .burst_time       (burst_time),
    .priority_level   (priority_level),
    .result_strobe    (result_strobe),
    .tick_time        (tick_time),
    .cpu_busy         (cpu_busy),
    .running_slot     (running_slot),
    .remaining_left   (remaining_left),
    .first_start_time (first_start_time),
    .just_finished    (just_finished),
    .finish_time      (finish_time),
    .all_done         (all_done)
  );

endmodule

// ===== rtl/nps_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module nps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/nps_ctrl.sv =====
// control state machine of the priority scheduler
// depends on nps_pkg and the shared assertion macros
`include "nonpreemptive_priority_scheduler_defines.svh"

module nps_ctrl import nps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      operation,
  input  nps_stat_t stat,
  output logic      busy,
  output nps_cmd_t  cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (stat.all_term) begin
            cmd.tick_idle = 1'b1;
          end else begin
            cmd.tick_begin = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last slot is evaluated here
      ST_DRAIN:  state_next = ST_SELECT;
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_next = ST_FETCH;
      end
      ST_FETCH:  state_next = ST_EXEC;
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.report = 1'b1;
        state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  `NPS_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
  `NPS_ASSERT_NEXT(a_report_ends, state == ST_REPORT, state == ST_IDLE, "report not followed by idle")
  `NPS_ASSERT_IMPL(a_scan_active, state == ST_SCAN, !stat.all_term, "scan entered with nothing to run")

endmodule

// ===== rtl/nps_dp.sv =====
// datapath of the priority scheduler: process tables, scan, selection, result registers
// depends on nps_pkg, nps_ram and the shared assertion macros
`include "nonpreemptive_priority_scheduler_defines.svh"

module nps_dp import nps_pkg::*; #(
  parameter int MAX_PROCESSES = 16,
  parameter int TIME_BITS     = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  nps_cmd_t           cmd,
  output nps_stat_t          stat,
  input  logic               active_count_we,
  input  logic [CFG_W-1:0]   active_count,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [FTIME_W-1:0] arrival_time,
  input  logic [BURST_W-1:0] burst_time,
  input  logic [FPRIO_W-1:0] priority_level,
  output logic               result_strobe,
  output logic [FTIME_W-1:0] tick_time,
  output logic               cpu_busy,
  output logic [SLOT_W-1:0]  running_slot,
  output logic [BURST_W-1:0] remaining_left,
  output logic [FTIME_W-1:0] first_start_time,
  output logic               just_finished,
  output logic [FTIME_W-1:0] finish_time,
  output logic               all_done
);

  localparam int SW = $clog2(MAX_PROCESSES);
  localparam int NW = $clog2(MAX_PROCESSES + 1);

  logic [CFG_W-1:0]         count_reg;
  logic [NW-1:0]            n_act;
  logic [TIME_BITS-1:0]     t_cur;
  logic [TIME_BITS-1:0]     t_inc;
  logic [SW-1:0]            owner;
  logic                     owner_valid;
  proc_state_t              status [MAX_PROCESSES];
  logic                     started [MAX_PROCESSES];
  logic [SW-1:0]            scan_idx;
  logic                     eval_vld;
  logic [SW-1:0]            eval_idx;
  logic                     found;
  logic [SW-1:0]            best_idx;
  logic [PRIORITY_BITS-1:0] best_prio;

  logic [TIME_BITS-1:0]     arr_rd;
  logic [PRIORITY_BITS-1:0] prio_rd;
  logic [BURST_W-1:0]       rem_rd;
  logic [TIME_BITS-1:0]     start_rd;
  logic [BURST_W-1:0]       rem_dec;
  logic                     fin;

  logic                     load_ok;
  logic [SW-1:0]            load_idx;
  logic                     admit;
  logic                     eval_ready;
  logic                     better;
  logic                     take;
  logic                     all_term;

  logic                     rem_we;
  logic [SW-1:0]            rem_waddr;
  logic [BURST_W-1:0]       rem_wdata;
  logic                     start_we;
  logic [SW-1:0]            start_waddr;
  logic [TIME_BITS-1:0]     start_wdata;

  // active count above the table depth acts as the full table
  always_comb begin
    if (32'(count_reg) > 32'(MAX_PROCESSES)) begin
      n_act = NW'(MAX_PROCESSES);
    end else begin
      n_act = NW'(count_reg);
    end
  end

  always_comb begin
    all_term = 1'b1;
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      if (i < int'(n_act) && status[i] != PS_DONE) begin
        all_term = 1'b0;
      end
    end
  end

  assign stat.all_term  = all_term;
  assign stat.scan_last = ((NW'(scan_idx) + NW'(1)) == n_act);

  assign t_inc    = t_cur + TIME_BITS'(1);
  assign load_ok  = cmd.load && (32'(slot) < 32'(MAX_PROCESSES));
  assign load_idx = SW'(slot);

  // admission and running minimum fused, one slot per cycle
  assign admit      = eval_vld && (status[eval_idx] == PS_NEW) && (arr_rd <= t_cur);
  assign eval_ready = eval_vld && ((status[eval_idx] == PS_READY) || admit);
  assign better     = eval_ready && !owner_valid && (!found || (prio_rd < best_prio));
  assign take       = cmd.select && !owner_valid && found;

  // zero remaining work saturates
  assign rem_dec = (rem_rd != '0) ? (rem_rd - BURST_W'(1)) : '0;
  assign fin     = (rem_dec == '0);

  assign rem_we      = load_ok || (cmd.exec && owner_valid);
  assign rem_waddr   = cmd.load ? load_idx : owner;
  assign rem_wdata   = cmd.load ? burst_time : rem_dec;
  assign start_we    = load_ok || (take && !started[best_idx]);
  assign start_waddr = cmd.load ? load_idx : best_idx;
  assign start_wdata = cmd.load ? '0 : t_cur;

  nps_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_PROCESSES)) u_arrival (
    .clk   (clk),
    .we    (load_ok),
    .waddr (load_idx),
    .wdata (TIME_BITS'(arrival_time)),
    .raddr (scan_idx),
    .rdata (arr_rd)
  );

  nps_ram #(.WIDTH(PRIORITY_BITS), .DEPTH(MAX_PROCESSES)) u_priority (
    .clk   (clk),
    .we    (load_ok),
    .waddr (load_idx),
    .wdata (PRIORITY_BITS'(priority_level)),
    .raddr (scan_idx),
    .rdata (prio_rd)
  );

  nps_ram #(.WIDTH(BURST_W), .DEPTH(MAX_PROCESSES)) u_remaining (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (owner),
    .rdata (rem_rd)
  );

  nps_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_PROCESSES)) u_start (
    .clk   (clk),
    .we    (start_we),
    .waddr (start_waddr),
    .wdata (start_wdata),
    .raddr (owner),
    .rdata (start_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg     <= '0;
      t_cur         <= '0;
      owner         <= '0;
      owner_valid   <= 1'b0;
      scan_idx      <= '0;
      eval_vld      <= 1'b0;
      found         <= 1'b0;
      result_strobe <= 1'b0;
      for (int i = 0; i < MAX_PROCESSES; i++) begin
        status[i]  <= PS_NEW;
        started[i] <= 1'b0;
      end
    end else begin
      result_strobe <= cmd.tick_idle || cmd.report;
      eval_vld      <= cmd.scan;
      if (active_count_we) begin
        count_reg <= active_count;
      end
      if (cmd.tick_begin) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else if (cmd.scan) begin
        scan_idx <= scan_idx + SW'(1);
      end
      if (better) begin
        found <= 1'b1;
      end
      if (load_ok) begin
        status[load_idx]  <= PS_NEW;
        started[load_idx] <= 1'b0;
        // reloading the owner frees the cpu
        if (owner_valid && owner == load_idx) begin
          owner_valid <= 1'b0;
        end
      end else if (admit) begin
        status[eval_idx] <= PS_READY;
      end else if (take) begin
        owner            <= best_idx;
        owner_valid      <= 1'b1;
        status[best_idx] <= PS_RUNNING;
        started[best_idx] <= 1'b1;
      end else if (cmd.exec) begin
        t_cur <= t_inc;
        if (owner_valid && fin) begin
          status[owner] <= PS_DONE;
          owner_valid   <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    eval_idx <= scan_idx;
    if (better) begin
      best_idx  <= eval_idx;
      best_prio <= prio_rd;
    end
    if (cmd.tick_idle) begin
      tick_time        <= FTIME_W'(t_cur);
      cpu_busy         <= 1'b0;
      running_slot     <= '0;
      remaining_left   <= '0;
      first_start_time <= '0;
      just_finished    <= 1'b0;
      finish_time      <= '0;
      all_done         <= 1'b1;
    end else if (cmd.exec) begin
      tick_time        <= FTIME_W'(t_cur);
      cpu_busy         <= owner_valid;
      running_slot     <= owner_valid ? SLOT_W'(owner) : '0;
      remaining_left   <= owner_valid ? rem_dec : '0;
      first_start_time <= owner_valid ? FTIME_W'(start_rd) : '0;
      just_finished    <= owner_valid && fin;
      finish_time      <= (owner_valid && fin) ? FTIME_W'(t_inc) : '0;
    end else if (cmd.report) begin
      all_done <= all_term;
    end
  end

  `NPS_ASSERT_IMPL(a_owner_running, owner_valid, status[owner] == PS_RUNNING, "cpu owner not marked running")
  `NPS_ASSERT_IMPL(a_idle_beat_clean, result_strobe && !cpu_busy, !just_finished && finish_time == '0, "idle beat reports a completion")
  `NPS_ASSERT_IMPL(a_finish_zero, result_strobe && just_finished, cpu_busy && remaining_left == '0, "finish beat with work left")

endmodule
